>>> src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants for the stepper position sequencer
// Mode and command codes, item classification and the front-to-back item.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  localparam int OPC_W   = 3;
  localparam int VALUE_W = 16;
  localparam int DELAY_W = 17;
  localparam int COUNT_W = 5;
  localparam int CMD_W   = 18;

  localparam logic [VALUE_W-1:0] LOOP_PERIOD_RST = 16'd200;
  localparam logic [VALUE_W-1:0] STEP_DELAY_RST  = 16'd10;

  // input opcodes
  localparam logic [OPC_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OPC_W-1:0] OP_CAL   = 3'd1;
  localparam logic [OPC_W-1:0] OP_GOTO  = 3'd2;
  localparam logic [OPC_W-1:0] OP_WAIT  = 3'd3;
  localparam logic [OPC_W-1:0] OP_SPEED = 3'd4;

  // controller modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_CAL  = 2'd2;

  // item classes from the front
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_CMD  = 2'd2;

  // queued command codes
  localparam logic [1:0] CMD_CAL   = 2'd0;
  localparam logic [1:0] CMD_GOTO  = 2'd1;
  localparam logic [1:0] CMD_WAIT  = 2'd2;
  localparam logic [1:0] CMD_SPEED = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] value;
    logic               det;
  } item_t;

endpackage

>>> src/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front: input stage of the sequencer
// Registers each input beat and classifies it as tick, command or nothing.
// ----------------------------------------------------------------------------
module sps_front
  import sps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OPC_W-1:0]   in_opcode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_detector_active,
  input  logic               q_full,
  output logic               push_valid,
  output item_t              push_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_nxt.value = in_value;
    item_nxt.det   = in_detector_active;
    item_nxt.kind  = KIND_CMD;
    item_nxt.cmd   = CMD_CAL;
    unique case (in_opcode)
      OP_TICK:  item_nxt.kind = KIND_TICK;
      OP_CAL:   item_nxt.cmd  = CMD_CAL;
      OP_GOTO:  item_nxt.cmd  = CMD_GOTO;
      OP_WAIT:  item_nxt.cmd  = CMD_WAIT;
      OP_SPEED: item_nxt.cmd  = CMD_SPEED;
      default:  item_nxt.kind = KIND_NONE;
    endcase
  end

  assign valid_nxt = accept || (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

>>> src/sps_item_queue.sv
// ----------------------------------------------------------------------------
// sps_item_queue: two-entry queue between front and back
// Lets the front keep taking beats while the back waits on the output.
// ----------------------------------------------------------------------------
module sps_item_queue
  import sps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t      ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign full       = cnt_r == 2'd2;
  assign push       = push_valid && !full;
  assign head_valid = cnt_r != 2'd0;
  assign head_item  = ent_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/sps_back.sv
// ----------------------------------------------------------------------------
// sps_back: execution part of the sequencer
// Command FIFO, delay counter, move and calibration control, result register.
// ----------------------------------------------------------------------------
module sps_back
  import sps_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  input  logic               head_valid,
  input  item_t              head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_step_right,
  output logic               out_step_left,
  output logic [1:0]         out_mode,
  output logic [VALUE_W-1:0] out_current_position,
  output logic [VALUE_W-1:0] out_target_position,
  output logic               out_delaying,
  output logic               out_command_dropped,
  output logic [COUNT_W-1:0] out_queue_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int P  = POSITION_BITS;

  logic [VALUE_W-1:0] loop_period_r;
  logic [1:0]         mode_r, mode_nxt;
  logic [P-1:0]       pos_r, pos_nxt;
  logic [P-1:0]       tgt_r, tgt_nxt;
  logic [VALUE_W-1:0] step_delay_r, step_delay_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               byp_r;
  logic [CMD_W-1:0]   byp_data_r;
  logic [CMD_W-1:0]   ram_rdata;
  logic [CMD_W-1:0]   head_cmd;
  logic [1:0]         head_code;
  logic [VALUE_W-1:0] head_val;
  logic               we;
  logic [CMD_W-1:0]   wdata;
  logic [DELAY_W-1:0] sleep;
  logic               right_nxt, left_nxt, dropped_nxt;
  logic               fire;

  logic               out_valid_r;
  logic               right_r, left_r, dropped_r, delaying_r;
  logic [1:0]         mode_out_r;
  logic [VALUE_W-1:0] pos_out_r, tgt_out_r;
  logic [COUNT_W-1:0] count_out_r;

  assign fire = head_valid && (!out_valid_r || !out_stall);
  assign pop  = fire;

  // head of the command fifo: prefetched ram word, or a word written just as it was read
  assign head_cmd  = byp_r ? byp_data_r : ram_rdata;
  assign head_code = head_cmd[CMD_W-1 -: 2];
  assign head_val  = head_cmd[VALUE_W-1:0];

  assign wdata = {head_item.cmd, head_item.value};

  always_comb begin
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    tgt_nxt        = tgt_r;
    step_delay_nxt = step_delay_r;
    delay_nxt      = delay_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    cnt_nxt        = cnt_r;
    we             = 1'b0;
    right_nxt      = 1'b0;
    left_nxt       = 1'b0;
    dropped_nxt    = 1'b0;
    sleep          = {1'b0, loop_period_r};
    if (fire && head_item.kind == KIND_TICK) begin
      if (delay_r != '0) begin
        delay_nxt = delay_r - DELAY_W'(1);
      end else begin
        unique case (mode_r)
          MODE_IDLE: begin
            if (cnt_r == '0) begin
              sleep = '0;
            end else begin
              rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
              cnt_nxt    = cnt_r - CW'(1);
              unique case (head_code)
                CMD_CAL:   mode_nxt = MODE_CAL;
                CMD_GOTO: begin
                  mode_nxt = MODE_MOVE;
                  tgt_nxt  = P'(head_val);
                end
                CMD_WAIT:  sleep = {1'b0, loop_period_r} + {1'b0, head_val};
                CMD_SPEED: step_delay_nxt = head_val;
                default:   mode_nxt = mode_r;
              endcase
            end
          end
          MODE_MOVE: begin
            if (pos_r < tgt_r) begin
              right_nxt = 1'b1;
              pos_nxt   = pos_r + P'(1);
            end else if (pos_r > tgt_r) begin
              left_nxt = 1'b1;
              pos_nxt  = pos_r - P'(1);
            end else begin
              mode_nxt = MODE_IDLE;
              pos_nxt  = '0;
              tgt_nxt  = '0;
            end
            sleep = {1'b0, loop_period_r} + {1'b0, step_delay_r};
          end
          MODE_CAL: begin
            if (!head_item.det) begin
              right_nxt = 1'b1;
            end else begin
              mode_nxt = MODE_IDLE;
              pos_nxt  = '0;
              tgt_nxt  = '0;
            end
          end
          default: mode_nxt = MODE_IDLE;
        endcase
        delay_nxt = sleep;
      end
    end else if (fire && head_item.kind == KIND_CMD) begin
      if (cnt_r == CW'(QUEUE_DEPTH)) begin
        dropped_nxt = 1'b1;
      end else begin
        we         = 1'b1;
        wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
        cnt_nxt    = cnt_r + CW'(1);
      end
    end
  end

  sps_ram #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr_r),
    .wdata (wdata),
    .raddr (rd_ptr_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_period_r <= LOOP_PERIOD_RST;
      mode_r        <= MODE_IDLE;
      pos_r         <= '0;
      tgt_r         <= '0;
      step_delay_r  <= STEP_DELAY_RST;
      delay_r       <= '0;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      cnt_r         <= '0;
      byp_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        loop_period_r <= cfg_wdata;
      end
      mode_r       <= mode_nxt;
      pos_r        <= pos_nxt;
      tgt_r        <= tgt_nxt;
      step_delay_r <= step_delay_nxt;
      delay_r      <= delay_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      cnt_r        <= cnt_nxt;
      byp_r        <= we && (wr_ptr_r == rd_ptr_nxt);
      out_valid_r  <= fire || (out_valid_r && out_stall);
    end
    byp_data_r <= wdata;
    if (fire) begin
      right_r     <= right_nxt;
      left_r      <= left_nxt;
      dropped_r   <= dropped_nxt;
      mode_out_r  <= mode_nxt;
      pos_out_r   <= VALUE_W'(pos_nxt);
      tgt_out_r   <= VALUE_W'(tgt_nxt);
      delaying_r  <= delay_nxt != '0;
      count_out_r <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_step_right       = right_r;
  assign out_step_left        = left_r;
  assign out_mode             = mode_out_r;
  assign out_current_position = pos_out_r;
  assign out_target_position  = tgt_out_r;
  assign out_delaying         = delaying_r;
  assign out_command_dropped  = dropped_r;
  assign out_queue_count      = count_out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("command fifo count beyond depth");

  a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> pos_r == '0 && tgt_r == '0)
    else $error("positions not cleared while idle");

  a_delay_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && head_item.kind == KIND_TICK && delay_r != '0
      |=> delay_r == $past(delay_r) - DELAY_W'(1))
    else $error("delay counter did not count down");

  a_step_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (right_r || left_r) |-> mode_out_r != MODE_IDLE)
    else $error("step pulse with idle mode");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dropped_r |-> cnt_r == CW'(QUEUE_DEPTH))
    else $error("command dropped with room in fifo");

endmodule

>>> src/stepper_position_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_position_sequencer: command-queued stepper move and calibrate control
//
//   port group  direction  handshake          payload
//   in_*        input      in_valid/in_stall  opcode, value, detector_active
//   out_*       output     out_valid/out_stall step pulses, mode, positions, status
//   cfg_*       input      cfg_we             loop_period
//
// One beat in and one beat out per cycle, sustained while out_stall is low.
// A beat passes through the input register, the item queue and the result register.
// The command fifo ram read is prefetched at the next read pointer each cycle.
// Reset is synchronous; the command ram needs no clearing pass.
// out_stall holds the result register; the two-entry item queue absorbs it.
// ----------------------------------------------------------------------------
module stepper_position_sequencer
  import sps_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OPC_W-1:0]   in_opcode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_detector_active,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_step_right,
  output logic               out_step_left,
  output logic [1:0]         out_mode,
  output logic [VALUE_W-1:0] out_current_position,
  output logic [VALUE_W-1:0] out_target_position,
  output logic               out_delaying,
  output logic               out_command_dropped,
  output logic [COUNT_W-1:0] out_queue_count
);

  logic  q_full;
  logic  push_valid;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  sps_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_value           (in_value),
    .in_detector_active (in_detector_active),
    .q_full             (q_full),
    .push_valid         (push_valid),
    .push_item          (push_item)
  );

  sps_item_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sps_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .head_valid           (head_valid),
    .head_item            (head_item),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_step_right       (out_step_right),
    .out_step_left        (out_step_left),
    .out_mode             (out_mode),
    .out_current_position (out_current_position),
    .out_target_position  (out_target_position),
    .out_delaying         (out_delaying),
    .out_command_dropped  (out_command_dropped),
    .out_queue_count      (out_queue_count)
  );

endmodule
